>>> rtl/pcv_pkg.sv
// Shared types and constants for the Pedersen commitment block.
package pcv_pkg;

    localparam int MOD_BITS_DEF = 64;
    localparam int FIELD_W = 64;
    localparam int ADDR_W = 5;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_BASE_G = 2'd1;
    localparam logic [1:0] REG_BASE_H = 2'd2;

    localparam logic [FIELD_W-1:0] MODULUS_RST = 64'd3;
    localparam logic [FIELD_W-1:0] BASE_RST = 64'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_G,
        S_RED_H,
        S_SQ,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_RED_G,
        OP_RED_H,
        OP_SQ,
        OP_MULB,
        OP_FIN
    } t_op;

    typedef struct packed {
        logic capture;
        logic start;
        t_op  op;
        logic exp_adv;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic exp_msb;
        logic exp_last;
        logic phase_h;
        logic p_small;
    } t_status;

endpackage

>>> rtl/pcv_if.sv
// Valid/ready channel interfaces for input and result items.
interface pcv_in_if;
    logic                        valid;
    logic                        ready;
    logic [pcv_pkg::FIELD_W-1:0] blinding_exp;
    logic [pcv_pkg::FIELD_W-1:0] message_exp;
    logic [pcv_pkg::FIELD_W-1:0] expected_commitment;
    modport source (output valid, blinding_exp, message_exp, expected_commitment,
                    input ready);
    modport sink (input valid, blinding_exp, message_exp, expected_commitment,
                  output ready);
endinterface

interface pcv_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcv_pkg::FIELD_W-1:0] commitment;
    logic                        matches_res;
    modport source (output valid, commitment, matches_res, input ready);
    modport sink (input valid, commitment, matches_res, output ready);
endinterface

>>> rtl/pcv_datapath.sv
// Datapath: operand registers, bit-serial modular multiply/reduce unit, exponent walk.
module pcv_datapath #(
    parameter int MOD_BITS = pcv_pkg::MOD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pcv_pkg::t_cmd               i_cmd,
    output pcv_pkg::t_status            o_st,
    input  logic [pcv_pkg::FIELD_W-1:0] i_p,
    input  logic [pcv_pkg::FIELD_W-1:0] i_g,
    input  logic [pcv_pkg::FIELD_W-1:0] i_h,
    input  logic [pcv_pkg::FIELD_W-1:0] i_r,
    input  logic [pcv_pkg::FIELD_W-1:0] i_m,
    input  logic [pcv_pkg::FIELD_W-1:0] i_e,
    output logic [pcv_pkg::FIELD_W-1:0] o_res,
    output logic                        o_match
);
    localparam int W = MOD_BITS;
    localparam int CW = (W > 1) ? $clog2(W) : 1;
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic [W-1:0] p_m;
    logic [W-1:0] r_m, r_e, r_exp, r_bg, r_bh, r_acc, r_gr, r_res;
    logic [W-1:0] r_u, r_x, r_a;
    logic [CW-1:0] r_cnt, r_bit;
    logic r_busy, r_phase;
    pcv_pkg::t_op r_op;

    logic [W:0] t_red, t_dbl, t_sum;
    logic [W-1:0] n_u, v_dbl;
    logic done;

    assign p_m = i_p[W-1:0];
    assign done = r_busy && (r_cnt == LAST);

    always_comb begin
        t_red = {r_u, r_x[W-1]};
        t_dbl = {r_u, 1'b0};
        if (t_dbl >= {1'b0, p_m}) begin
            t_dbl = t_dbl - {1'b0, p_m};
        end
        v_dbl = t_dbl[W-1:0];
        t_sum = {1'b0, v_dbl} + {1'b0, r_a};
        if (t_sum >= {1'b0, p_m}) begin
            t_sum = t_sum - {1'b0, p_m};
        end
        if (t_red >= {1'b0, p_m}) begin
            t_red = t_red - {1'b0, p_m};
        end
        if (r_op == pcv_pkg::OP_RED_G || r_op == pcv_pkg::OP_RED_H) begin
            n_u = t_red[W-1:0];
        end else if (r_x[W-1]) begin
            n_u = t_sum[W-1:0];
        end else begin
            n_u = v_dbl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start && !r_busy) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_m <= i_m[W-1:0];
            r_e <= i_e[W-1:0];
            r_exp <= i_r[W-1:0];
            r_bit <= '0;
            r_phase <= 1'b0;
            r_acc <= W'(1);
            r_res <= '0;
        end
        if (i_cmd.start && !r_busy) begin
            r_op <= i_cmd.op;
            r_cnt <= '0;
            r_u <= '0;
            case (i_cmd.op)
                pcv_pkg::OP_RED_G: begin
                    r_x <= i_g[W-1:0];
                    r_a <= '0;
                end
                pcv_pkg::OP_RED_H: begin
                    r_x <= i_h[W-1:0];
                    r_a <= '0;
                end
                pcv_pkg::OP_SQ: begin
                    r_x <= r_acc;
                    r_a <= r_acc;
                end
                pcv_pkg::OP_MULB: begin
                    r_x <= r_phase ? r_bh : r_bg;
                    r_a <= r_acc;
                end
                pcv_pkg::OP_FIN: begin
                    r_x <= r_acc;
                    r_a <= r_gr;
                end
                default: begin
                    r_x <= '0;
                    r_a <= '0;
                end
            endcase
        end else if (r_busy) begin
            r_u <= n_u;
            r_x <= r_x << 1;
            r_cnt <= r_cnt + CW'(1);
        end
        if (done) begin
            case (r_op)
                pcv_pkg::OP_RED_G: r_bg <= n_u;
                pcv_pkg::OP_RED_H: r_bh <= n_u;
                pcv_pkg::OP_FIN: r_res <= n_u;
                default: begin
                    // The last step of g^r parks its product and restarts the accumulator.
                    if (i_cmd.exp_adv && r_bit == LAST && !r_phase) begin
                        r_gr <= n_u;
                        r_acc <= W'(1);
                    end else begin
                        r_acc <= n_u;
                    end
                end
            endcase
        end
        // Exponent advance: either the next bit, or switch from r to m.
        if (i_cmd.exp_adv) begin
            if (r_bit == LAST) begin
                if (!r_phase) begin
                    r_exp <= r_m;
                    r_bit <= '0;
                    r_phase <= 1'b1;
                end
            end else begin
                r_bit <= r_bit + CW'(1);
                r_exp <= r_exp << 1;
            end
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = done;
    assign o_st.exp_msb = r_exp[W-1];
    assign o_st.exp_last = (r_bit == LAST);
    assign o_st.phase_h = r_phase;
    assign o_st.p_small = (p_m >> 1) == '0;

    assign o_res = pcv_pkg::FIELD_W'(r_res);
    assign o_match = (r_res == r_e);

    a_res_below_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_op == pcv_pkg::OP_FIN) |=> (r_res < p_m))
        else $error("commitment not reduced below modulus");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !done) |=> r_busy)
        else $error("serial unit stopped early");
endmodule

>>> rtl/pcv_ctrl.sv
// Controller: sequences reductions, square-and-multiply steps and result handoff.
module pcv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    input  pcv_pkg::t_status i_st,
    output pcv_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_load_out
);
    pcv_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcv_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_st.p_small ? pcv_pkg::S_OUT : pcv_pkg::S_RED_G;
                end
            end
            pcv_pkg::S_RED_G: if (i_st.done) n_state = pcv_pkg::S_RED_H;
            pcv_pkg::S_RED_H: if (i_st.done) n_state = pcv_pkg::S_SQ;
            pcv_pkg::S_SQ: begin
                if (i_st.done) begin
                    if (i_st.exp_msb) begin
                        n_state = pcv_pkg::S_MUL;
                    end else if (i_st.exp_last && i_st.phase_h) begin
                        n_state = pcv_pkg::S_FIN;
                    end
                end
            end
            pcv_pkg::S_MUL: begin
                if (i_st.done) begin
                    n_state = (i_st.exp_last && i_st.phase_h) ? pcv_pkg::S_FIN
                                                             : pcv_pkg::S_SQ;
                end
            end
            pcv_pkg::S_FIN: if (i_st.done) n_state = pcv_pkg::S_OUT;
            pcv_pkg::S_OUT: if (i_out_free) n_state = pcv_pkg::S_IDLE;
            default: n_state = pcv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.op = pcv_pkg::OP_SQ;
        o_in_ready = 1'b0;
        o_load_out = 1'b0;
        case (r_state)
            pcv_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            pcv_pkg::S_RED_G: begin
                o_cmd.op = pcv_pkg::OP_RED_G;
                o_cmd.start = !i_st.busy;
            end
            pcv_pkg::S_RED_H: begin
                o_cmd.op = pcv_pkg::OP_RED_H;
                o_cmd.start = !i_st.busy;
            end
            pcv_pkg::S_SQ: begin
                o_cmd.op = pcv_pkg::OP_SQ;
                o_cmd.start = !i_st.busy;
                o_cmd.exp_adv = i_st.done && !i_st.exp_msb;
            end
            pcv_pkg::S_MUL: begin
                o_cmd.op = pcv_pkg::OP_MULB;
                o_cmd.start = !i_st.busy;
                o_cmd.exp_adv = i_st.done;
            end
            pcv_pkg::S_FIN: begin
                o_cmd.op = pcv_pkg::OP_FIN;
                o_cmd.start = !i_st.busy;
            end
            pcv_pkg::S_OUT: o_load_out = i_out_free;
            default: o_cmd = '0;
        endcase
    end

    a_busy_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.busy |-> (r_state != pcv_pkg::S_IDLE && r_state != pcv_pkg::S_OUT))
        else $error("serial unit running outside a compute state");
endmodule

>>> rtl/pedersen_commit_verify.sv
// Top level: Pedersen commitment c = g^r * h^m mod p with compare against expected value.
//
//  channel  | dir | handshake        | payload
//  i_in     | in  | valid/ready      | blinding_exp, message_exp, expected_commitment
//  o_out    | out | valid/ready      | commitment, matches_res
//  apb      | in  | psel/penable     | modulus @0x00, base_g @0x08, base_h @0x10
//
// Each modular multiply or base reduction runs through one shared bit-serial unit; an item
// needs two base reductions, one squaring per exponent bit, one multiply per set exponent
// bit and a final multiply, plus intake and handoff. When the modulus is below 2 the item
// skips the computation and goes straight to handoff.
// Reset (i_rst_n, synchronous) loads p = 3, g = h = 1 and empties the result register.
// A finished result waits in the output register; the next item is taken once the
// result has moved there.
module pedersen_commit_verify #(
    parameter int MOD_BITS = pcv_pkg::MOD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pcv_in_if.sink                      i_in,
    pcv_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcv_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcv_pkg::FIELD_W-1:0] pwdata,
    output logic [pcv_pkg::FIELD_W-1:0] prdata,
    output logic                        pready
);
    logic [pcv_pkg::FIELD_W-1:0] r_p, r_g, r_h;
    logic [pcv_pkg::FIELD_W-1:0] r_out_c, res;
    logic r_out_valid, r_out_m, match, out_free, load_out;
    logic [1:0] reg_idx;
    pcv_pkg::t_cmd cmd;
    pcv_pkg::t_status st;

    assign pready = 1'b1;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= pcv_pkg::MODULUS_RST;
            r_g <= pcv_pkg::BASE_RST;
            r_h <= pcv_pkg::BASE_RST;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            case (reg_idx)
                pcv_pkg::REG_MODULUS: r_p <= pwdata;
                pcv_pkg::REG_BASE_G: r_g <= pwdata;
                pcv_pkg::REG_BASE_H: r_h <= pwdata;
                default: r_p <= r_p;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pcv_pkg::REG_MODULUS: prdata = r_p;
            pcv_pkg::REG_BASE_G: prdata = r_g;
            pcv_pkg::REG_BASE_H: prdata = r_h;
            default: prdata = '0;
        endcase
    end

    pcv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_ready (i_in.ready),
        .o_load_out (load_out)
    );

    pcv_datapath #(.MOD_BITS(MOD_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_st    (st),
        .i_p     (r_p),
        .i_g     (r_g),
        .i_h     (r_h),
        .i_r     (i_in.blinding_exp),
        .i_m     (i_in.message_exp),
        .i_e     (i_in.expected_commitment),
        .o_res   (res),
        .o_match (match)
    );

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_c <= res;
            r_out_m <= match;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.commitment = r_out_c;
    assign o_out.matches_res = r_out_m;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second item taken while one is in progress");
    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result register overwritten before it was taken");
endmodule
